FILE: rtl/radix_digit_converter_assert.svh
// Assertion macros shared by the checker of the radix digit converter.
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define RDC_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radix_digit_converter: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define RDC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("radix_digit_converter: next-cycle check failed");

`endif

FILE: rtl/rdc_pkg.sv
// Shared constants and functions of the radix digit converter.
`default_nettype none

package rdc_pkg;

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [6:0] GLYPH_ZERO = 7'd48;   // '0'
    localparam logic [6:0] GLYPH_ALPHA = 7'd87;  // 'a' minus ten
    localparam logic [5:0] DIGIT_TEN = 6'd10;

    // floor(2^32 / r) for r in 2..36
    function automatic logic [31:0] rdc_recip(input logic [5:0] r);
        logic [31:0] res;
        case (r)
            6'd2:    res = 32'd2147483648;
            6'd3:    res = 32'd1431655765;
            6'd4:    res = 32'd1073741824;
            6'd5:    res = 32'd858993459;
            6'd6:    res = 32'd715827882;
            6'd7:    res = 32'd613566756;
            6'd8:    res = 32'd536870912;
            6'd9:    res = 32'd477218588;
            6'd10:   res = 32'd429496729;
            6'd11:   res = 32'd390451572;
            6'd12:   res = 32'd357913941;
            6'd13:   res = 32'd330382099;
            6'd14:   res = 32'd306783378;
            6'd15:   res = 32'd286331153;
            6'd16:   res = 32'd268435456;
            6'd17:   res = 32'd252645135;
            6'd18:   res = 32'd238609294;
            6'd19:   res = 32'd226050910;
            6'd20:   res = 32'd214748364;
            6'd21:   res = 32'd204522252;
            6'd22:   res = 32'd195225786;
            6'd23:   res = 32'd186737708;
            6'd24:   res = 32'd178956970;
            6'd25:   res = 32'd171798691;
            6'd26:   res = 32'd165191049;
            6'd27:   res = 32'd159072862;
            6'd28:   res = 32'd153391689;
            6'd29:   res = 32'd148102320;
            6'd30:   res = 32'd143165576;
            6'd31:   res = 32'd138547332;
            6'd32:   res = 32'd134217728;
            6'd33:   res = 32'd130150524;
            6'd34:   res = 32'd126322567;
            6'd35:   res = 32'd122713351;
            6'd36:   res = 32'd119304647;
            default: res = 32'd0;
        endcase
        return res;
    endfunction

    // digit value to lowercase ASCII
    function automatic logic [6:0] rdc_glyph(input logic [5:0] d);
        logic [6:0] res;
        if (d < DIGIT_TEN)
        begin
            res = GLYPH_ZERO + {1'b0, d};
        end
        else
        begin
            res = GLYPH_ALPHA + {1'b0, d};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rdc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/rdc_front.sv
// Front end: masks the value, clamps the radix and looks up its reciprocal.
`default_nettype none

module rdc_front #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [31:0]           value,
    input  wire logic [5:0]            radix,
    output      logic                  push_valid,
    input  wire logic                  push_ready,
    output      logic [2*((VALUE_BITS < 32) ? VALUE_BITS : 32)+5:0] push_data
);

    localparam int W = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    logic [5:0]   radix_sat;
    logic [31:0]  recip_full;
    logic [W-1:0] recip_w;

    always_comb
    begin
        if (radix < rdc_pkg::RADIX_MIN)
        begin
            radix_sat = rdc_pkg::RADIX_MIN;
        end
        else if (radix > rdc_pkg::RADIX_MAX)
        begin
            radix_sat = rdc_pkg::RADIX_MAX;
        end
        else
        begin
            radix_sat = radix;
        end
    end

    // floor(2^W / r) is the top W bits of floor(2^32 / r)
    assign recip_full = rdc_pkg::rdc_recip(radix_sat);
    assign recip_w    = recip_full[31 -: W];

    assign push_valid = in_valid;
    assign in_ready   = push_ready;
    assign push_data  = {value[W-1:0], radix_sat, recip_w};

endmodule

`default_nettype wire

FILE: rtl/rdc_queue.sv
// Two-entry request queue between the front end and the converter core.
`default_nettype none

module rdc_queue #(
    parameter int WIDTH = 70
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output      logic             push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output      logic             pop_valid,
    input  wire logic             pop_ready,
    output      logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rdc_back.sv
// Converter core: reciprocal divide loop into the digit store, then reverse readout.
`default_nettype none

module rdc_back #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pop_valid,
    output      logic       pop_ready,
    input  wire logic [2*((VALUE_BITS < 32) ? VALUE_BITS : 32)+5:0] pop_data,
    output      logic       out_valid,
    input  wire logic       out_ready,
    output      logic [6:0] digit_char,
    output      logic [5:0] digit_count,
    output      logic       last
);

    localparam int W  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int AW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FIX,
        S_RD,
        S_LOAD
    } state_t;

    state_t         state_reg, state_next;
    logic [W-1:0]   quot_reg, quot_next;
    logic [5:0]     radix_reg, radix_next;
    logic [W-1:0]   recip_reg, recip_next;
    logic [2*W-1:0] prod_reg, prod_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic           out_valid_reg, out_valid_next;
    logic [6:0]     char_reg, char_next;
    logic [5:0]     dcount_reg, dcount_next;
    logic           last_reg, last_next;

    logic [W-1:0]   q0;
    logic [W+5:0]   qd;
    logic [6:0]     r0;
    logic           corr;
    logic [6:0]     rem7;
    logic [5:0]     digit;
    logic [W-1:0]   q_new;
    logic [CW+5:0]  cnt_ext;

    logic           ram_we;
    logic           ram_re;
    logic [5:0]     ram_rdata;

    // quotient estimate is low by at most one; true remainder stays below 2*radix
    assign q0    = prod_reg[2*W-1:W];
    assign qd    = {6'd0, q0} * {{W{1'b0}}, radix_reg};
    assign r0    = quot_reg[6:0] - qd[6:0];
    assign corr  = (r0 >= {1'b0, radix_reg});
    assign rem7  = corr ? (r0 - {1'b0, radix_reg}) : r0;
    assign digit = rem7[5:0];
    assign q_new = q0 + {{(W-1){1'b0}}, corr};

    assign cnt_ext = {6'd0, cnt_reg};

    assign ram_we = (state_reg == S_FIX);
    assign ram_re = (state_reg == S_RD);

    rdc_ram #(
        .WIDTH (6),
        .DEPTH (VALUE_BITS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (digit),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign pop_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        quot_next      = quot_reg;
        radix_next     = radix_reg;
        recip_next     = recip_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        dcount_next    = dcount_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    quot_next  = pop_data[2*W+5:W+6];
                    radix_next = pop_data[W+5:W];
                    recip_next = pop_data[W-1:0];
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = {{W{1'b0}}, quot_reg} * {{W{1'b0}}, recip_reg};
                state_next = S_FIX;
            end
            S_FIX:
            begin
                // zero input still yields one '0' digit here
                quot_next = q_new;
                cnt_next  = cnt_reg + {{(CW-1){1'b0}}, 1'b1};
                if (q_new == '0)
                begin
                    idx_next   = cnt_reg;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_RD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    char_next      = rdc_pkg::rdc_glyph(ram_rdata);
                    dcount_next    = cnt_ext[5:0];
                    last_next      = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - {{(CW-1){1'b0}}, 1'b1};
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            quot_reg      <= '0;
            radix_reg     <= '0;
            recip_reg     <= '0;
            prod_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            dcount_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quot_reg      <= quot_next;
            radix_reg     <= radix_next;
            recip_reg     <= recip_next;
            prod_reg      <= prod_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            dcount_reg    <= dcount_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign digit_char  = char_reg;
    assign digit_count = dcount_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

FILE: rtl/radix_digit_converter.sv
// Top level of the radix digit converter: front end, request queue, converter core.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in      | input     | in_valid / in_ready  | value[31:0], radix[5:0]
//   out     | output    | out_valid/ out_ready | digit_char[6:0], digit_count[5:0],
//           |           |                      | last
//
// For each digit the core steps through a multiply state and a fix state in the
// multiply-by-reciprocal divide loop, then later a read state and a load state
// to bring it back through the digit store's single registered read port; an
// idle state picks up each request.
// Reset is asynchronous, active low; the digit store is not cleared, since every
// entry read out was written by the same request.
// The two-entry queue accepts requests while the core works until it is full;
// a stalled out channel holds its result and freezes the core at the readout step.
`default_nettype none

module radix_digit_converter #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [31:0] value,
    input  wire logic [5:0]  radix,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [6:0]  digit_char,
    output      logic [5:0]  digit_count,
    output      logic        last
);

    // working width of the value: the low VALUE_BITS bits, at most the port width
    localparam int W  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    // queue entry: value, clamped radix, reciprocal
    localparam int QW = 2 * W + 6;

    logic          push_valid;
    logic          push_ready;
    logic [QW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [QW-1:0] pop_data;

    rdc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .radix      (radix),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rdc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // divide loop and ordered readout; owns the digit store and the output register
    rdc_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digit_char  (digit_char),
        .digit_count (digit_count),
        .last        (last)
    );

endmodule

`default_nettype wire

FILE: rtl/rdc_checker.sv
// Port-level checker of the radix digit converter and its bind.
`default_nettype none

`include "radix_digit_converter_assert.svh"

module rdc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [31:0] value,
    input wire logic [5:0]  radix,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [6:0]  digit_char,
    input wire logic [5:0]  digit_count,
    input wire logic        last
);

    logic [5:0] idx_reg, idx_next;
    logic [5:0] cnt_hold_reg, cnt_hold_next;
    logic       out_fire;
    logic       in_fire;

    assign out_fire = out_valid && out_ready;
    assign in_fire  = in_valid && in_ready && (value != 32'd0 || radix != 6'd0);

    always_comb
    begin
        idx_next      = idx_reg;
        cnt_hold_next = cnt_hold_reg;
        if (out_fire)
        begin
            idx_next      = last ? 6'd0 : idx_reg + 6'd1;
            cnt_hold_next = digit_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= 6'd0;
            cnt_hold_reg <= 6'd0;
        end
        else
        begin
            idx_reg      <= idx_next;
            cnt_hold_reg <= cnt_hold_next;
        end
    end

    `RDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(digit_char) && $stable(digit_count) && $stable(last))
    `RDC_ASSERT_IMPL(a_char_range, out_valid || in_fire,
        !out_valid || (digit_char >= 7'd48 && digit_char <= 7'd57) ||
        (digit_char >= 7'd97 && digit_char <= 7'd122))
    `RDC_ASSERT_IMPL(a_count_steady, out_valid && idx_reg != 6'd0, digit_count == cnt_hold_reg)
    `RDC_ASSERT_IMPL(a_last_place, out_valid, last == ((idx_reg + 6'd1) == digit_count))
    `RDC_ASSERT_IMPL(a_no_lead_zero, out_valid && idx_reg == 6'd0 && digit_count != 6'd1,
        digit_char != 7'd48)

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);

`default_nettype wire
